// File: rtl/trimmed_mean_window_filter_core_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_CORE_ASSERT_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TMWF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TMWF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tmwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmwf_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MIN_WINDOW      = 5;

  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int WL_W      = 5;
  localparam int DC_W      = 3;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(8);
  localparam logic [DC_W-1:0] DC_RESET = DC_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_PREFILL = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FILLING = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_ERROR   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'd0,
    REG_DROP_COUNT    = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  // occ: cell holds a value; lt: incoming value ranks below this cell
  typedef struct packed {
    logic occ;
    logic lt;
  } cell_flags_t;

endpackage

`default_nettype wire

// File: rtl/tmwf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tmwf_cell #(
  parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tmwf_pkg::cell_op_t            op,
  input  wire logic signed [SAMPLE_BITS-1:0] din,
  input  wire logic signed [SAMPLE_BITS-1:0] left_val,
  input  wire tmwf_pkg::cell_flags_t         left_flags,
  input  wire logic signed [SAMPLE_BITS-1:0] right_val,
  input  wire logic                          right_occ,
  output logic signed [SAMPLE_BITS-1:0]      val,
  output tmwf_pkg::cell_flags_t              flags
);

  logic                          occ;
  logic                          occ_next;
  logic signed [SAMPLE_BITS-1:0] val_next;

  // an empty cell ranks as +infinity
  assign flags.occ = occ;
  assign flags.lt  = !occ || (din < val);

  always_comb begin
    val_next = val;
    occ_next = occ;
    case (op)
      tmwf_pkg::OP_CLEAR: begin
        occ_next = 1'b0;
      end
      tmwf_pkg::OP_INSERT: begin
        if (flags.lt) begin
          if (left_flags.lt) begin
            val_next = left_val;
            occ_next = left_flags.occ;
          end else begin
            val_next = din;
            occ_next = 1'b1;
          end
        end
      end
      tmwf_pkg::OP_SHIFT: begin
        val_next = right_val;
        occ_next = right_occ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

// File: rtl/tmwf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tmwf_div #(
  parameter int DVD_W = 21,
  parameter int DVS_W = 5,
  parameter int Q_W   = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [DVD_W-1:0] dividend,
  input  wire logic        [DVS_W-1:0] divisor,
  output logic                         done,
  output logic signed [Q_W-1:0]        quotient
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic              neg;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVD_W-1:0]  quo_signed;

  // restoring division on the magnitude, one quotient bit per cycle
  assign trial = {rem, quo[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  assign quo_signed = neg ? (~quo + DVD_W'(1)) : quo;
  assign quotient   = quo_signed[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
        end
      end
      done <= !start && busy && (step == STEP_W'(DVD_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DVD_W-1];
      quo <= dividend[DVD_W-1] ? (~dividend + DVD_W'(1)) : dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

`include "trimmed_mean_window_filter_core_assert.svh"

  `TMWF_ASSERT_IMP(a_start_idle, clk, rst, start, !busy, "divider started while busy")
  `TMWF_ASSERT_IMP(a_done_ends, clk, rst, done, !busy, "divider done while still stepping")

endmodule

`default_nettype wire

// File: rtl/trimmed_mean_window_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Trimmed-mean filter over a sliding window of signed samples. One result
// per request. Clear, prefill, unused-kind, error and not-yet-full requests
// go straight from idle to the done state. For a sample that completes a
// full window, the window is streamed into a chain of sorting cells one
// value a cycle, shifted back out in ascending order into the accumulator,
// and the kept sum goes through a one-bit-per-cycle divider. One request is
// in flight at a time; a finished result waits in the output register while
// the next request is taken. Config writes are for idle periods only.
module trimmed_mean_window_filter_core #(
  parameter int WINDOW_MAX  = tmwf_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // sample [SAMPLE_BITS-1:0], zero pad above
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  // kind [1:0]
  input  wire logic [tmwf_pkg::KIND_W-1:0]        s_tuser,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // filtered [SAMPLE_BITS-1:0], zero pad above
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
  // status [1:0]
  output logic [tmwf_pkg::STATUS_W-1:0]           m_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic                               cfg_we,
  input  wire logic [tmwf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tmwf_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W  = ($clog2(WINDOW_MAX + 1) > tmwf_pkg::WL_W) ?
                          $clog2(WINDOW_MAX + 1) : tmwf_pkg::WL_W;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX + 1);

  tmwf_pkg::state_t state;
  tmwf_pkg::state_t state_next;

  logic [tmwf_pkg::WL_W-1:0] window_len;
  logic [tmwf_pkg::DC_W-1:0] drop_cnt;

  logic signed [SAMPLE_BITS-1:0] store [WINDOW_MAX];
  logic [IDX_W-1:0]              wr_pos;
  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              cnt;
  logic signed [SUM_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] pend_val;
  logic [tmwf_pkg::STATUS_W-1:0] pend_stat;

  logic                          in_fire;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] sample;
  tmwf_pkg::kind_t               kind;
  logic [CNT_W-1:0]              wl_ext;
  logic [CNT_W-1:0]              dc_ext;
  logic [CNT_W-1:0]              dc2;
  logic [CNT_W-1:0]              kept;
  logic                          cfg_ok;
  logic [IDX_W-1:0]              pos;
  logic [CNT_W-1:0]              pos_inc;
  logic [IDX_W-1:0]              pos_wrap;
  logic [CNT_W-1:0]              fill_clamp;
  logic [CNT_W-1:0]              fill_new;
  logic                          win_full;
  logic                          go_load;
  logic                          cnt_last;
  logic                          in_trim;
  logic [DATA_W-1:0]             out_word;

  tmwf_pkg::cell_op_t            cell_op;
  logic signed [SAMPLE_BITS-1:0] ins_val;
  logic signed [SAMPLE_BITS-1:0] cell_val   [WINDOW_MAX];
  tmwf_pkg::cell_flags_t         cell_flags [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] head;

  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sample   = s_tdata[SAMPLE_BITS-1:0];
  assign kind     = tmwf_pkg::kind_t'(s_tuser);

  assign wl_ext = CNT_W'(window_len);
  assign dc_ext = CNT_W'(drop_cnt);
  assign dc2    = CNT_W'({drop_cnt, 1'b0});
  assign kept   = wl_ext - dc2;
  assign cfg_ok = (wl_ext >= CNT_W'(tmwf_pkg::MIN_WINDOW)) &&
                  (wl_ext <= CNT_W'(WINDOW_MAX)) && (dc2 < wl_ext);

  // window shrunk under a running position: restart at slot 0
  assign pos        = (CNT_W'(wr_pos) < wl_ext) ? wr_pos : '0;
  assign pos_inc    = CNT_W'(pos) + CNT_W'(1);
  assign pos_wrap   = (pos_inc >= wl_ext) ? '0 : pos_inc[IDX_W-1:0];
  assign fill_clamp = (fill > wl_ext) ? wl_ext : fill;
  assign fill_new   = (fill_clamp < wl_ext) ? fill_clamp + CNT_W'(1) : fill_clamp;
  assign win_full   = fill >= wl_ext;

  assign go_load  = (kind == tmwf_pkg::KIND_SAMPLE) && cfg_ok && (fill_new >= wl_ext);
  assign cnt_last = cnt == (wl_ext - CNT_W'(1));
  assign in_trim  = (cnt >= dc_ext) && (cnt < (wl_ext - dc_ext));

  assign ins_val = store[cnt[IDX_W-1:0]];
  assign head    = cell_val[0];

  always_comb begin
    out_word = '0;
    out_word[SAMPLE_BITS-1:0] = pend_val;
  end

  // sorting chain, ascending from cell 0
  for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lval;
    tmwf_pkg::cell_flags_t         lflags;
    logic signed [SAMPLE_BITS-1:0] rval;
    logic                          rocc;

    if (gi == 0) begin : g_first
      assign lval   = '0;
      assign lflags = '{occ: 1'b1, lt: 1'b0};
    end else begin : g_mid
      assign lval   = cell_val[gi-1];
      assign lflags = cell_flags[gi-1];
    end

    if (gi == WINDOW_MAX - 1) begin : g_last
      assign rval = '0;
      assign rocc = 1'b0;
    end else begin : g_inner
      assign rval = cell_val[gi+1];
      assign rocc = cell_flags[gi+1].occ;
    end

    tmwf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (cell_op),
      .din       (ins_val),
      .left_val  (lval),
      .left_flags(lflags),
      .right_val (rval),
      .right_occ (rocc),
      .val       (cell_val[gi]),
      .flags     (cell_flags[gi])
    );
  end

  tmwf_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W),
    .Q_W  (SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc),
    .divisor (kept),
    .done    (div_done),
    .quotient(div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      tmwf_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = go_load ? tmwf_pkg::ST_LOAD : tmwf_pkg::ST_DONE;
        end
      end
      tmwf_pkg::ST_LOAD: begin
        if (cnt_last) begin
          state_next = tmwf_pkg::ST_SUM;
        end
      end
      tmwf_pkg::ST_SUM: begin
        if (cnt_last) begin
          state_next = tmwf_pkg::ST_DIV_START;
        end
      end
      tmwf_pkg::ST_DIV_START: begin
        state_next = tmwf_pkg::ST_DIV_WAIT;
      end
      tmwf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = tmwf_pkg::ST_DONE;
        end
      end
      tmwf_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tmwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmwf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    cell_op   = tmwf_pkg::OP_HOLD;
    case (state)
      tmwf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cell_op  = tmwf_pkg::OP_CLEAR;
      end
      tmwf_pkg::ST_LOAD: begin
        cell_op = tmwf_pkg::OP_INSERT;
      end
      tmwf_pkg::ST_SUM: begin
        cell_op = tmwf_pkg::OP_SHIFT;
      end
      tmwf_pkg::ST_DIV_START: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmwf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= tmwf_pkg::WL_RESET;
      drop_cnt   <= tmwf_pkg::DC_RESET;
      for (int i = 0; i < WINDOW_MAX; i++) begin
        store[i] <= '0;
      end
      wr_pos   <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (tmwf_pkg::cfg_reg_t'(cfg_index))
          tmwf_pkg::REG_WINDOW_LENGTH: window_len <= cfg_data[tmwf_pkg::WL_W-1:0];
          tmwf_pkg::REG_DROP_COUNT:    drop_cnt   <= cfg_data[tmwf_pkg::DC_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        case (kind)
          tmwf_pkg::KIND_CLEAR: begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
              store[i] <= '0;
            end
            wr_pos <= '0;
            fill   <= '0;
          end
          tmwf_pkg::KIND_PREFILL: begin
            if (cfg_ok) begin
              for (int i = 0; i < WINDOW_MAX; i++) begin
                if (CNT_W'(i) < wl_ext) begin
                  store[i] <= sample;
                end
              end
              wr_pos <= '0;
              fill   <= wl_ext;
            end
          end
          tmwf_pkg::KIND_SAMPLE: begin
            if (cfg_ok) begin
              store[pos] <= sample;
              wr_pos     <= pos_wrap;
              fill       <= fill_new;
            end
          end
          default: begin
          end
        endcase
      end

      if (state == tmwf_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cnt <= '0;
      acc <= '0;
      case (kind)
        tmwf_pkg::KIND_CLEAR: begin
          pend_val  <= '0;
          pend_stat <= cfg_ok ? tmwf_pkg::STAT_FILLING : tmwf_pkg::STAT_ERROR;
        end
        tmwf_pkg::KIND_PREFILL: begin
          pend_val  <= cfg_ok ? sample : '0;
          pend_stat <= cfg_ok ? tmwf_pkg::STAT_FULL : tmwf_pkg::STAT_ERROR;
        end
        tmwf_pkg::KIND_SAMPLE: begin
          pend_val  <= cfg_ok ? sample : '0;
          pend_stat <= !cfg_ok ? tmwf_pkg::STAT_ERROR :
                       (fill_new >= wl_ext) ? tmwf_pkg::STAT_FULL :
                       tmwf_pkg::STAT_FILLING;
        end
        default: begin
          pend_val  <= '0;
          pend_stat <= !cfg_ok ? tmwf_pkg::STAT_ERROR :
                       win_full ? tmwf_pkg::STAT_FULL : tmwf_pkg::STAT_FILLING;
        end
      endcase
    end else begin
      case (state)
        tmwf_pkg::ST_LOAD: begin
          cnt <= cnt_last ? '0 : cnt + CNT_W'(1);
        end
        tmwf_pkg::ST_SUM: begin
          cnt <= cnt + CNT_W'(1);
          if (in_trim) begin
            acc <= acc + {{(SUM_W-SAMPLE_BITS){head[SAMPLE_BITS-1]}}, head};
          end
        end
        tmwf_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            pend_val <= div_quot;
          end
        end
        default: begin
        end
      endcase
    end

    if (state == tmwf_pkg::ST_DONE && out_free) begin
      m_tdata <= out_word;
      m_tuser <= pend_stat;
    end
  end

`include "trimmed_mean_window_filter_core_assert.svh"

  `TMWF_ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_fire, (state == tmwf_pkg::ST_LOAD) || (state == tmwf_pkg::ST_DONE), "request not followed by load or done")
  `TMWF_ASSERT_IMP(a_head_occupied, clk, rst, state == tmwf_pkg::ST_SUM, cell_flags[0].occ, "sort chain ran dry while summing")
  `TMWF_ASSERT_IMP(a_div_done_wait, clk, rst, div_done, state == tmwf_pkg::ST_DIV_WAIT, "divider finished outside wait state")
  `TMWF_ASSERT_NXT(a_done_to_out, clk, rst, (state == tmwf_pkg::ST_DONE) && out_free, m_tvalid, "finished result not presented")

endmodule

`default_nettype wire

// File: verif/tmwf_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register-write ports of the trimmed-mean
// filter, keeps its own model of the window and checks every result in order.
module tmwf_checker
  import tmwf_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DW          = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DW-1:0]        s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [DW-1:0]        m_tdata,
  input  logic [STATUS_W-1:0]  m_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int MAX_PRINT = 100;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered;
    status_t                status;
  } filter_result_t;

  logic signed [SAMPLE_BITS-1:0] window_vals [WINDOW_MAX];
  int                            wr_pos;
  int                            fill_cnt;
  logic [WL_W-1:0]               win_len;
  logic [DC_W-1:0]               drop_n;
  filter_result_t                expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report(input string msg);
    if (fail_count < MAX_PRINT) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic cfg_valid();
    if (int'(win_len) < MIN_WINDOW || int'(win_len) > WINDOW_MAX) return 1'b0;
    return (2 * int'(drop_n)) < int'(win_len);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < WINDOW_MAX; i++) window_vals[i] = '0;
    wr_pos   = 0;
    fill_cnt = 0;
  endtask

  // rank the active window, drop drop_n at each end, average the rest
  function automatic logic [SAMPLE_BITS-1:0] trimmed_avg();
    logic signed [SAMPLE_BITS-1:0] ranked [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] v;
    longint acc;
    int     j;
    int     wl;
    int     dc;
    wl  = int'(win_len);
    dc  = int'(drop_n);
    acc = 0;
    for (int i = 0; i < wl; i++) begin
      v = window_vals[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    for (int i = dc; i < wl - dc; i++) acc += longint'(ranked[i]);
    return SAMPLE_BITS'(acc / longint'(wl - 2 * dc));
  endfunction

  task automatic filter_step(input logic [KIND_W-1:0] kind,
                             input logic signed [SAMPLE_BITS-1:0] val,
                             output filter_result_t res);
    int   wl;
    int   pos;
    logic ok;
    wl           = int'(win_len);
    ok           = cfg_valid();
    res.filtered = '0;
    res.status   = STAT_ERROR;
    if (kind == KIND_CLEAR) begin
      clear_window();
      res.status = ok ? STAT_FILLING : STAT_ERROR;
    end else if (kind != KIND_SAMPLE && kind != KIND_PREFILL) begin
      // unused code: no state change, just report where the window stands
      if (ok) res.status = (fill_cnt >= wl) ? STAT_FULL : STAT_FILLING;
    end else if (ok && kind == KIND_PREFILL) begin
      for (int i = 0; i < wl; i++) window_vals[i] = val;
      wr_pos       = 0;
      fill_cnt     = wl;
      res.filtered = val;
      res.status   = STAT_FULL;
    end else if (ok) begin
      // window may have shrunk since the last write
      pos              = (wr_pos < wl) ? wr_pos : 0;
      window_vals[pos] = val;
      pos++;
      if (pos >= wl) pos = 0;
      wr_pos = pos;
      if (fill_cnt > wl) fill_cnt = wl;
      if (fill_cnt < wl) fill_cnt++;
      if (fill_cnt >= wl) begin
        res.filtered = trimmed_avg();
        res.status   = STAT_FULL;
      end else begin
        res.filtered = val;
        res.status   = STAT_FILLING;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    filter_result_t want;
    if (rst) begin
      clear_window();
      win_len = WL_RESET;
      drop_n  = DC_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: win_len = cfg_data[WL_W-1:0];
          REG_DROP_COUNT:    drop_n  = cfg_data[DC_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result: filtered %0d status %0d",
                           $signed(m_tdata[SAMPLE_BITS-1:0]), m_tuser));
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== DW'(want.filtered))
            report($sformatf("filtered mismatch: got %0d exp %0d",
                             $signed(m_tdata[SAMPLE_BITS-1:0]),
                             $signed(want.filtered)));
          if (m_tuser !== want.status)
            report($sformatf("status mismatch: got %0d exp %0d", m_tuser, want.status));
        end
      end
      if (s_tvalid && s_tready) begin
        filter_step(s_tuser, s_tdata[SAMPLE_BITS-1:0], want);
        expected_results.push_back(want);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import tmwf_pkg::*;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int DW           = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 700;
  localparam int RX_HOLD      = 400;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 64;
  localparam int WD_LIMIT     = 2000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic [DW-1:0]        s_tdata   = '0;
  logic [KIND_W-1:0]    s_tuser   = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [DW-1:0]        m_tdata;
  logic [STATUS_W-1:0]  m_tuser;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold_req = 1'b0;

  trimmed_mean_window_filter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tmwf_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD) @(negedge clk);
      end
      gap = rx_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 63) == 0) rx_idle_on = ~rx_idle_on;
    end
  end

  // starts and ends at a falling edge; valid stays up so a zero gap chains
  task automatic send(input logic [KIND_W-1:0] kind, input logic [SAMPLE_BITS-1:0] val);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= DW'(val);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_out();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [WL_W-1:0] wl, input logic [DC_W-1:0] dc);
    drain_out();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data  <= CFG_W'(wl);
    @(negedge clk);
    cfg_index <= REG_DROP_COUNT;
    cfg_data  <= CFG_W'(dc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2:       return SAMPLE_BITS'($signed($urandom_range(0, 16)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return KIND_SAMPLE;
    if (r < 90) return KIND_PREFILL;
    if (r < 96) return KIND_CLEAR;
    return KIND_UNUSED;
  endfunction

  initial begin : stimulus
    int sent;
    int phase;
    int n_items;
    int wl;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset config: window 8, drop 1
    send(KIND_CLEAR,   16'hFFFF);
    send(KIND_UNUSED,  16'h1234);
    send(KIND_SAMPLE,  16'h7FFF);
    send(KIND_SAMPLE,  16'h8000);
    send(KIND_SAMPLE,  16'd100);
    send(KIND_SAMPLE,  -16'sd100);
    send(KIND_SAMPLE,  16'd5);
    send(KIND_SAMPLE,  16'd7);
    send(KIND_SAMPLE,  16'h5555);
    send(KIND_SAMPLE,  16'hAAAA);   // window now full
    send(KIND_SAMPLE,  16'hFFFF);
    send(KIND_UNUSED,  16'h0000);
    send(KIND_PREFILL, 16'h8000);
    send(KIND_SAMPLE,  16'h7FFF);
    send(KIND_PREFILL, 16'h7FFF);
    send(KIND_SAMPLE,  16'h7FFF);
    // below minimum window: everything errors, clear still clears
    set_config(5'd4, 3'd0);
    send(KIND_SAMPLE,  16'h0001);
    send(KIND_PREFILL, 16'h0002);
    send(KIND_UNUSED,  16'h0003);
    send(KIND_CLEAR,   16'h0004);
    // drop count too large for the window
    set_config(5'd10, 3'd5);
    send(KIND_SAMPLE,  16'h0009);
    set_config(5'd0, 3'd0);
    send(KIND_SAMPLE,  16'h000A);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: set_config(5'd16, 3'd7);
        1: set_config(5'd5, 3'd2);
        2: set_config(5'd16, 3'd0);
        3: set_config(5'd31, 3'd7);
        4: set_config(5'd5, 3'd0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            set_config(WL_W'($urandom_range(0, 31)), DC_W'($urandom_range(0, 7)));
          end else begin
            wl = $urandom_range(5, 16);
            set_config(WL_W'(wl), DC_W'($urandom_range(0, (wl - 1) / 2)));
          end
        end
      endcase
      tx_idle_on = (phase % 3 != 1);
      // back-pressure the result side so the request side stalls
      if (phase == 1 || phase == 7) rx_hold_req = 1'b1;
      n_items = $urandom_range(40, 70);
      for (int i = 0; i < n_items; i++) begin
        send(rand_kind(), rand_sample());
        if ($urandom_range(0, 99) == 0 || (phase == 5 && i == 20)) drain_out();
      end
      sent += n_items;
      phase++;
    end

    drain_out();
    repeat (TAIL) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tmwf_pkg.sv
rtl/tmwf_cell.sv
rtl/tmwf_div.sv
rtl/trimmed_mean_window_filter_core.sv
verif/tmwf_checker.sv
verif/tb.sv
